>>> src/descriptor_slot_allocator_defines.svh
// ----------------------------------------------------------------------------
// descriptor_slot_allocator_defines
// Assertion macros of the descriptor slot allocator, used by dsa_ctrl.
// ----------------------------------------------------------------------------
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_DEFINES_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types and constants of the descriptor slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package dsa_pkg;

  localparam int NUM_SLOTS_DEF = 1024;
  localparam int WORD_BITS_DEF = 64;
  localparam int ACTION_W      = 3;
  localparam int SLOT_W        = 10;
  localparam int STATUS_W      = 2;
  localparam int RELEASED_W    = 11;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC    = 3'd0,
    ACT_FREE     = 3'd1,
    ACT_CLAIM    = 3'd2,
    ACT_SET_FLAG = 3'd3,
    ACT_GET_FLAG = 3'd4,
    ACT_SWEEP    = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_INVAL  = 2'd1,
    ST_FULL   = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SPLIT,
    S_OP,
    S_SEARCH,
    S_SWEEP,
    S_RESP
  } state_t;

  typedef struct packed {
    status_t                 status;
    logic [SLOT_W-1:0]       slot_out;
    logic                    flag_out;
    logic [RELEASED_W-1:0]   released;
  } res_t;

endpackage

`default_nettype wire

>>> src/descriptor_slot_allocator.sv
// ----------------------------------------------------------------------------
// descriptor_slot_allocator
// Lowest-free-slot descriptor allocator (at or above the requested slot)
// over an in-use bitmap and a close-on-exec bitmap, in word-wide RAMs.
//
//   channel  signals                         direction  beat
//   in       in_valid in_ready               sink       action slot flag
//   out      out_valid out_ready             source     status slot_out
//                                                       flag_out released
//
// a bad action or slot is answered without a RAM access; free, claim, set
//   flag and get flag read one word, allocate reads words until one has a
//   free slot, sweep reads every word; one RAM read-modify-write per word
// one action in flight; the next is taken once the result enters the output
//   register, which holds it while out_ready is low
// after reset both RAMs are cleared one word per cycle (NUM_WORDS words,
//   16 at defaults) with in_ready low
// ----------------------------------------------------------------------------
`default_nettype none

module descriptor_slot_allocator
  import dsa_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [ACTION_W-1:0]   action,
  input  wire logic [SLOT_W-1:0]     slot,
  input  wire logic                  flag,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [STATUS_W-1:0]        status,
  output logic [SLOT_W-1:0]          slot_out,
  output logic                       flag_out,
  output logic [RELEASED_W-1:0]      released
);

  localparam int NUM_WORDS = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic                 res_room;
  logic                 res_push;
  res_t                 res;
  res_t                 out_res;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_use;
  logic [WORD_BITS-1:0] rd_exec;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_use;
  logic [WORD_BITS-1:0] wr_exec;

  dsa_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .slot     (slot),
    .flag     (flag),
    .res_room (res_room),
    .res_push (res_push),
    .res      (res),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_use   (rd_use),
    .rd_exec  (rd_exec),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_use   (wr_use),
    .wr_exec  (wr_exec)
  );

  // in-use bitmap
  dsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_use_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_use),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_use)
  );

  // close-on-exec bitmap
  dsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_exec_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_exec),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_exec)
  );

  // output register
  assign res_room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res <= res;
    end
  end

  assign status   = out_res.status;
  assign slot_out = out_res.slot_out;
  assign flag_out = out_res.flag_out;
  assign released = out_res.released;

endmodule

`default_nettype wire

>>> src/dsa_ram.sv
// ----------------------------------------------------------------------------
// dsa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/dsa_ctrl.sv
// ----------------------------------------------------------------------------
// dsa_ctrl
// Action sequencer: splits the slot into word and bit, then reads, modifies
// and writes back the in-use and close-on-exec words, walking words for
// allocate and sweep.
// ----------------------------------------------------------------------------
`default_nettype none

`include "descriptor_slot_allocator_defines.svh"

module dsa_ctrl
  import dsa_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF,
  localparam int NUM_WORDS = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS,
  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [ACTION_W-1:0]  action,
  input  wire logic [SLOT_W-1:0]    slot,
  input  wire logic                 flag,
  input  wire logic                 res_room,
  output logic                      res_push,
  output res_t                      res,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  wire logic [WORD_BITS-1:0] rd_use,
  input  wire logic [WORD_BITS-1:0] rd_exec,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [WORD_BITS-1:0]      wr_use,
  output logic [WORD_BITS-1:0]      wr_exec
);

  localparam int BW = $clog2(WORD_BITS);
  localparam int PW = $clog2(WORD_BITS + 1);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int IW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int RECIP = (1 << IW) / WORD_BITS;
  localparam int LAST_WORD = NUM_WORDS - 1;
  localparam int LAST_VALID = NUM_SLOTS - (NUM_WORDS - 1) * WORD_BITS;

  function automatic logic [WORD_BITS-1:0] tail_mask_f();
    logic [WORD_BITS-1:0] m;
    for (int i = 0; i < WORD_BITS; i++) begin
      m[i] = (i >= LAST_VALID);
    end
    return m;
  endfunction

  localparam logic [WORD_BITS-1:0] TAIL_MASK = tail_mask_f();

  state_t                  state, state_next;
  logic [ACTION_W-1:0]     act, act_next;
  logic [IW-1:0]           slot_i, slot_i_next;
  logic                    flg, flg_next;
  logic [IW-1:0]           quo, quo_next;
  logic [AW-1:0]           word, word_next;
  logic [BW-1:0]           bitx, bitx_next;
  logic [WORD_BITS-1:0]    below, below_next;
  logic [IW-1:0]           base, base_next;
  logic [RELEASED_W-1:0]   cnt, cnt_next;
  res_t                    res_next;

  logic [2*IW-1:0]         prod;
  logic [IW-1:0]           quo_wb;
  logic [IW-1:0]           rem;
  logic                    rem_over;
  logic [IW-1:0]           word_q;
  logic [IW-1:0]           bit_r;
  logic                    in_range;
  logic [WORD_BITS-1:0]    below_c;
  logic [WORD_BITS-1:0]    srch_m;
  logic [BW-1:0]           lz;
  logic [WORD_BITS-1:0]    lz_mask;
  logic [IW-1:0]           found;
  logic [WORD_BITS-1:0]    bm;
  logic                    hit;
  logic [PW-1:0]           pop;
  logic [RELEASED_W-1:0]   cnt_sum;
  logic                    last_word;

  // slot split by reciprocal multiply, one correction step
  assign prod     = (2*IW)'(slot_i) * (2*IW)'(RECIP);
  assign quo_wb   = quo * IW'(WORD_BITS);
  assign rem      = slot_i - quo_wb;
  assign rem_over = (rem >= IW'(WORD_BITS));
  assign word_q   = rem_over ? quo + IW'(1) : quo;
  assign bit_r    = rem_over ? rem - IW'(WORD_BITS) : rem;
  assign in_range = (slot_i < IW'(NUM_SLOTS));

  assign last_word = (word == AW'(LAST_WORD));
  assign srch_m    = rd_use | below | (last_word ? TAIL_MASK : '0);
  assign lz_mask   = WORD_BITS'(1) << lz;
  assign found     = base + IW'(lz);
  assign bm        = WORD_BITS'(1) << bitx;
  assign hit       = rd_use[bitx];
  assign cnt_sum   = cnt + RELEASED_W'(pop);

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      below_c[i] = (i < int'(bit_r));
    end
  end

  // lowest zero of the search word
  always_comb begin
    lz = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!srch_m[i]) begin
        lz = BW'(i);
      end
    end
  end

  always_comb begin
    pop = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      pop = pop + PW'(rd_exec[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      word  <= '0;
    end else begin
      state <= state_next;
      word  <= word_next;
    end
  end

  always_ff @(posedge clk) begin
    act    <= act_next;
    slot_i <= slot_i_next;
    flg    <= flg_next;
    quo    <= quo_next;
    bitx   <= bitx_next;
    below  <= below_next;
    base   <= base_next;
    cnt    <= cnt_next;
    res    <= res_next;
  end

  always_comb begin
    state_next  = state;
    act_next    = act;
    slot_i_next = slot_i;
    flg_next    = flg;
    quo_next    = quo;
    word_next   = word;
    bitx_next   = bitx;
    below_next  = below;
    base_next   = base;
    cnt_next    = cnt;
    res_next    = res;
    in_ready    = 1'b0;
    res_push    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = word;
    wr_en       = 1'b0;
    wr_addr     = word;
    wr_use      = rd_use;
    wr_exec     = rd_exec;

    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_use  = '0;
        wr_exec = '0;
        if (last_word) begin
          word_next  = '0;
          state_next = S_IDLE;
        end else begin
          word_next = word + AW'(1);
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          act_next    = action;
          slot_i_next = IW'(slot);
          flg_next    = flag;
          state_next  = S_DIV;
        end
      end

      S_DIV: begin
        quo_next   = prod[2*IW-1:IW];
        state_next = S_SPLIT;
      end

      S_SPLIT: begin
        res_next.status   = ST_OK;
        res_next.slot_out = slot_i[SLOT_W-1:0];
        res_next.flag_out = 1'b0;
        res_next.released = '0;
        priority if (act == ACT_SWEEP) begin
          res_next.slot_out = '0;
          word_next  = '0;
          cnt_next   = '0;
          rd_en      = 1'b1;
          rd_addr    = '0;
          state_next = S_SWEEP;
        end else if (act > ACT_SWEEP) begin
          res_next.status   = ST_INVAL;
          res_next.slot_out = '0;
          state_next        = S_RESP;
        end else if (!in_range) begin
          res_next.status = ST_INVAL;
          state_next      = S_RESP;
        end else begin
          word_next  = word_q[AW-1:0];
          bitx_next  = bit_r[BW-1:0];
          below_next = below_c;
          base_next  = slot_i - bit_r;
          rd_en      = 1'b1;
          rd_addr    = word_q[AW-1:0];
          state_next = (act == ACT_ALLOC) ? S_SEARCH : S_OP;
        end
      end

      S_SEARCH: begin
        priority if (srch_m != '1) begin
          wr_en             = 1'b1;
          wr_use            = rd_use | lz_mask;
          wr_exec           = rd_exec & ~lz_mask;
          res_next.slot_out = found[SLOT_W-1:0];
          state_next        = S_RESP;
        end else if (last_word) begin
          res_next.status = ST_FULL;
          state_next      = S_RESP;
        end else begin
          word_next  = word + AW'(1);
          base_next  = base + IW'(WORD_BITS);
          below_next = '0;
          rd_en      = 1'b1;
          rd_addr    = word + AW'(1);
        end
      end

      S_OP: begin
        state_next = S_RESP;
        priority if (act == ACT_CLAIM) begin
          res_next.flag_out = hit;
          wr_en             = 1'b1;
          wr_use            = rd_use | bm;
          wr_exec           = rd_exec & ~bm;
        end else if (!hit) begin
          res_next.status = ST_UNUSED;
        end else if (act == ACT_FREE) begin
          wr_en   = 1'b1;
          wr_use  = rd_use & ~bm;
          wr_exec = rd_exec & ~bm;
        end else if (act == ACT_SET_FLAG) begin
          wr_en   = 1'b1;
          wr_exec = flg ? (rd_exec | bm) : (rd_exec & ~bm);
        end else begin
          res_next.flag_out = rd_exec[bitx];
        end
      end

      S_SWEEP: begin
        wr_en   = 1'b1;
        wr_use  = rd_use & ~rd_exec;
        wr_exec = '0;
        if (last_word) begin
          res_next.released = cnt_sum;
          state_next        = S_RESP;
        end else begin
          cnt_next  = cnt_sum;
          word_next = word + AW'(1);
          rd_en     = 1'b1;
          rd_addr   = word + AW'(1);
        end
      end

      S_RESP: begin
        res_push = res_room;
        if (res_room) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  `DSA_ASSERT_NOW(a_no_rw_collide, rd_en && wr_en, rd_addr != wr_addr, "read and write hit one word")
  `DSA_ASSERT_NOW(a_push_has_room, res_push, res_room, "result pushed into a full output stage")
  `DSA_ASSERT_NOW(a_full_only_alloc, res_push && res.status == ST_FULL, act == ACT_ALLOC, "no-free-slot status outside allocate")
  `DSA_ASSERT_NOW(a_released_sweep, res_push && res.released != '0, act == ACT_SWEEP, "release count outside sweep")
  `DSA_ASSERT_NEXT(a_ready_after_push, res_push, in_ready, "not ready after a result")

endmodule

`default_nettype wire
